>>> sv/u8dec_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8dec_pkg;

	localparam int CP_W   = 31;
	localparam int BYTE_W = 8;
	localparam int ST_W   = 2;

	localparam logic [ST_W-1:0] ST_CHAR    = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
	localparam logic [ST_W-1:0] ST_END     = 2'd2;

	typedef enum logic [2:0] {
		PH_NONE = 3'b001,
		PH_LEAD = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		logic [ST_W-1:0] status;
	} res_t;

endpackage
`default_nettype wire

>>> sv/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// A byte goes from the input register through the single-pass step on the state
// registers to the result register: one byte per cycle unless the output stalls.
// Bytes that only extend a sequence (or a pending high surrogate) give no result.
// Reset (arst_n low) clears the decode state and empties both registers at once.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [u8dec_pkg::BYTE_W-1:0] byte_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [u8dec_pkg::CP_W-1:0]       code_point,
	output logic [u8dec_pkg::ST_W-1:0]       status
);

	logic                           valid_s1;
	logic [u8dec_pkg::BYTE_W-1:0]   byte_s1;
	logic                           advance, out_free;
	u8dec_pkg::res_t                res;

	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
		end
	end

	u8dec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	u8dec_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && res.valid),
		.res        (res),
		.out_ready  (out_ready),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.code_point (code_point),
		.status     (status)
	);

endmodule
`default_nettype wire

>>> sv/u8dec_core.sv
// Decoder state registers and the single-pass byte step logic.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [u8dec_pkg::BYTE_W-1:0] byte_s1,
	output u8dec_pkg::res_t                  res
);

	logic [2:0]                   rem_q, len_q, rem_n, len_n, rem_dec;
	logic [u8dec_pkg::CP_W-1:0]   acc_q, acc_n, acc_sh, lim;
	logic [9:0]                   hs_q, hs_n;
	u8dec_pkg::phase_t            phase_q, phase_n;
	logic [20:0]                  pair_cp;
	logic                         drop;

	always_comb begin
		rem_n   = rem_q;
		len_n   = len_q;
		acc_n   = acc_q;
		hs_n    = hs_q;
		phase_n = phase_q;
		drop    = 1'b0;
		res     = '0;
		rem_dec = rem_q - 3'd1;
		acc_sh  = {acc_q[u8dec_pkg::CP_W-7:0], byte_s1[5:0]};
		pair_cp = 21'h10000 + {1'b0, hs_q, acc_sh[9:0]};
		case (len_q)
			3'd2:    lim = 31'h80;
			3'd4:    lim = 31'h10000;
			3'd5:    lim = 31'h200000;
			default: lim = 31'h4000000;
		endcase

		if (byte_s1 == '0) begin
			res.valid  = 1'b1;
			res.status = u8dec_pkg::ST_END;
		end else if (rem_q != 3'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				res.valid  = 1'b1;
				res.status = u8dec_pkg::ST_INVALID;
			end else if (rem_dec != 3'd0) begin
				acc_n = acc_sh;
				rem_n = rem_dec;
			end else if (phase_q == u8dec_pkg::PH_LOW) begin
				res.valid = 1'b1;
				if (acc_sh inside {[31'hDC00:31'hDFFF]}) begin
					res.status     = u8dec_pkg::ST_CHAR;
					res.code_point = {10'd0, pair_cp};
				end else begin
					res.status = u8dec_pkg::ST_INVALID;
				end
			end else if (len_q == 3'd3) begin
				if (acc_sh inside {[31'hD800:31'hDBFF]}) begin
					// hold the high half until its partner arrives
					hs_n    = acc_sh[9:0];
					phase_n = u8dec_pkg::PH_LEAD;
					acc_n   = '0;
					len_n   = 3'd0;
					rem_n   = 3'd0;
				end else begin
					res.valid = 1'b1;
					if (acc_sh < 31'h800 || acc_sh inside {[31'hDC00:31'hDFFF]}) begin
						res.status = u8dec_pkg::ST_INVALID;
					end else begin
						res.status     = u8dec_pkg::ST_CHAR;
						res.code_point = acc_sh;
					end
				end
			end else begin
				res.valid = 1'b1;
				if (acc_sh < lim) begin
					res.status = u8dec_pkg::ST_INVALID;
				end else begin
					res.status     = u8dec_pkg::ST_CHAR;
					res.code_point = acc_sh;
				end
			end
		end else if (phase_q == u8dec_pkg::PH_LEAD) begin
			if (byte_s1 inside {[8'hE0:8'hEF]}) begin
				len_n   = 3'd3;
				rem_n   = 3'd2;
				acc_n   = {27'd0, byte_s1[3:0]};
				phase_n = u8dec_pkg::PH_LOW;
			end else begin
				res.valid  = 1'b1;
				res.status = u8dec_pkg::ST_INVALID;
			end
		end else if (byte_s1 inside {[8'h01:8'h7F]}) begin
			res.valid      = 1'b1;
			res.status     = u8dec_pkg::ST_CHAR;
			res.code_point = {24'd0, byte_s1[6:0]};
		end else if (byte_s1 inside {[8'hC0:8'hDF]}) begin
			len_n = 3'd2; rem_n = 3'd1; acc_n = {26'd0, byte_s1[4:0]};
		end else if (byte_s1 inside {[8'hE0:8'hEF]}) begin
			len_n = 3'd3; rem_n = 3'd2; acc_n = {27'd0, byte_s1[3:0]};
		end else if (byte_s1 inside {[8'hF0:8'hF7]}) begin
			len_n = 3'd4; rem_n = 3'd3; acc_n = {28'd0, byte_s1[2:0]};
		end else if (byte_s1 inside {[8'hF8:8'hFB]}) begin
			len_n = 3'd5; rem_n = 3'd4; acc_n = {29'd0, byte_s1[1:0]};
		end else if (byte_s1 inside {[8'hFC:8'hFD]}) begin
			len_n = 3'd6; rem_n = 3'd5; acc_n = {30'd0, byte_s1[0]};
		end else begin
			res.valid  = 1'b1;
			res.status = u8dec_pkg::ST_INVALID;
		end

		// every result leaves the decoder at a lead byte
		if (res.valid) begin
			drop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			hs_q    <= '0;
			phase_q <= u8dec_pkg::PH_NONE;
		end else if (advance) begin
			if (drop) begin
				rem_q   <= '0;
				len_q   <= '0;
				acc_q   <= '0;
				hs_q    <= '0;
				phase_q <= u8dec_pkg::PH_NONE;
			end else begin
				rem_q   <= rem_n;
				len_q   <= len_n;
				acc_q   <= acc_n;
				hs_q    <= hs_n;
				phase_q <= phase_n;
			end
		end
	end

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> rem_q == 3'd0 && phase_q == u8dec_pkg::PH_NONE)
		else $error("state not cleared after result");
	a_low_half_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == u8dec_pkg::PH_LOW |-> len_q == 3'd3)
		else $error("low surrogate half without 3-byte length");
	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 3'd0 |-> rem_q < len_q)
		else $error("remaining count exceeds sequence length");
	a_cp_zero_non_char: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != u8dec_pkg::ST_CHAR |-> res.code_point == '0)
		else $error("nonzero code point on non-character result");

endmodule
`default_nettype wire

>>> sv/u8dec_out.sv
// Result register on the output channel.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_out (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire u8dec_pkg::res_t            res,
	input  wire logic                       out_ready,
	output logic                            out_free,
	output logic                            out_valid,
	output logic [u8dec_pkg::CP_W-1:0]      code_point,
	output logic [u8dec_pkg::ST_W-1:0]      status
);

	logic                         valid_q;
	logic [u8dec_pkg::CP_W-1:0]   cp_q;
	logic [u8dec_pkg::ST_W-1:0]   st_q;

	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign code_point = cp_q;
	assign status     = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q <= res.code_point;
			st_q <= res.status;
		end
	end

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the UTF-8 stream decoder: directed, random and stall tests.
`timescale 1ns / 1ps
module tb;

	localparam int TIMEOUT_CYCLES = 500000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 750;
	localparam int STREAM_BYTES   = 150;

	typedef struct packed {
		logic [u8dec_pkg::CP_W-1:0] cp;
		logic [u8dec_pkg::ST_W-1:0] st;
	} decoded_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [u8dec_pkg::BYTE_W-1:0] byte_value = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [u8dec_pkg::CP_W-1:0]   code_point;
	logic [u8dec_pkg::ST_W-1:0]   status;

	// decoder state mirrored by the predictor
	logic [2:0]                 dec_left  = '0;
	logic [2:0]                 dec_len   = '0;
	logic [u8dec_pkg::CP_W-1:0] dec_acc   = '0;
	logic [9:0]                 dec_hi    = '0;
	u8dec_pkg::phase_t          dec_phase = u8dec_pkg::PH_NONE;

	decoded_t expected_q[$];

	int  errors        = 0;
	int  cycles        = 0;
	int  n_bytes       = 0;
	int  n_chars       = 0;
	int  n_invalid     = 0;
	int  n_end         = 0;
	int  n_pairs       = 0;
	int  hold_requests = 0;
	int  holds_done    = 0;
	bit  idle_on       = 1'b1;

	utf8_stream_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.status     (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic record_result(input logic [u8dec_pkg::CP_W-1:0] cp,
			input logic [u8dec_pkg::ST_W-1:0] st);
		decoded_t r;
		r.cp = (st == u8dec_pkg::ST_CHAR) ? cp : '0;
		r.st = st;
		dec_left  = '0;
		dec_len   = '0;
		dec_acc   = '0;
		dec_hi    = '0;
		dec_phase = u8dec_pkg::PH_NONE;
		expected_q.push_back(r);
	endtask

	task automatic start_sequence(input logic [2:0] len,
			input logic [u8dec_pkg::CP_W-1:0] bits);
		dec_len  = len;
		dec_left = len - 3'd1;
		dec_acc  = bits;
	endtask

	task automatic close_sequence();
		logic [u8dec_pkg::CP_W-1:0] v;
		logic [u8dec_pkg::CP_W-1:0] floor_v;
		v = dec_acc;
		if (dec_phase == u8dec_pkg::PH_LOW) begin
			if (v >= 31'h0DC00 && v <= 31'h0DFFF) begin
				n_pairs++;
				record_result(31'h10000 + {11'd0, dec_hi, 10'd0} + {21'd0, v[9:0]},
					u8dec_pkg::ST_CHAR);
			end else begin
				record_result('0, u8dec_pkg::ST_INVALID);
			end
		end else if (dec_len == 3'd3 && v >= 31'h0D800 && v <= 31'h0DBFF) begin
			// hold the high half until the low half completes
			dec_hi    = v[9:0];
			dec_phase = u8dec_pkg::PH_LEAD;
			dec_acc   = '0;
			dec_len   = '0;
		end else if (dec_len == 3'd3 && v >= 31'h0DC00 && v <= 31'h0DFFF) begin
			record_result('0, u8dec_pkg::ST_INVALID);
		end else begin
			case (dec_len)
				3'd2:    floor_v = 31'h80;
				3'd3:    floor_v = 31'h800;
				3'd4:    floor_v = 31'h10000;
				3'd5:    floor_v = 31'h200000;
				default: floor_v = 31'h4000000;
			endcase
			if (v < floor_v)
				record_result('0, u8dec_pkg::ST_INVALID);
			else
				record_result(v, u8dec_pkg::ST_CHAR);
		end
	endtask

	task automatic predict_decode(input logic [u8dec_pkg::BYTE_W-1:0] b);
		if (b == 8'h00) begin
			record_result('0, u8dec_pkg::ST_END);
		end else if (dec_left != 3'd0) begin
			if (b[7:6] != 2'b10) begin
				record_result('0, u8dec_pkg::ST_INVALID);
			end else begin
				dec_acc  = {dec_acc[u8dec_pkg::CP_W-7:0], b[5:0]};
				dec_left = dec_left - 3'd1;
				if (dec_left == 3'd0)
					close_sequence();
			end
		end else if (dec_phase == u8dec_pkg::PH_LEAD) begin
			if (b < 8'hE0 || b > 8'hEF) begin
				record_result('0, u8dec_pkg::ST_INVALID);
			end else begin
				start_sequence(3'd3, {27'd0, b[3:0]});
				dec_phase = u8dec_pkg::PH_LOW;
			end
		end else if (b <= 8'h7F) begin
			record_result({23'd0, b}, u8dec_pkg::ST_CHAR);
		end else if (b <= 8'hBF) begin
			record_result('0, u8dec_pkg::ST_INVALID);
		end else if (b <= 8'hDF) begin
			start_sequence(3'd2, {26'd0, b[4:0]});
		end else if (b <= 8'hEF) begin
			start_sequence(3'd3, {27'd0, b[3:0]});
		end else if (b <= 8'hF7) begin
			start_sequence(3'd4, {28'd0, b[2:0]});
		end else if (b <= 8'hFB) begin
			start_sequence(3'd5, {29'd0, b[1:0]});
		end else if (b <= 8'hFD) begin
			start_sequence(3'd6, {30'd0, b[0]});
		end else begin
			record_result('0, u8dec_pkg::ST_INVALID);
		end
	endtask

	task automatic send_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
		predict_decode(b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// result checker and receiver stalls
	initial begin
		decoded_t exp_res;
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				case (status)
					u8dec_pkg::ST_CHAR:    n_chars++;
					u8dec_pkg::ST_INVALID: n_invalid++;
					default:               n_end++;
				endcase
				if (expected_q.size() == 0) begin
					$error("unexpected beat: code_point %h status %0d", code_point, status);
					errors++;
				end else begin
					exp_res = expected_q.pop_front();
					if (code_point !== exp_res.cp) begin
						$error("code_point: expected %h, got %h", exp_res.cp, code_point);
						errors++;
					end
					if (status !== exp_res.st) begin
						$error("status: expected %0d, got %0d", exp_res.st, status);
						errors++;
					end
				end
			end
			if (hold_left == 0 && holds_done < hold_requests)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					holds_done++;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready  <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [u8dec_pkg::BYTE_W-1:0] cont_byte();
		logic [5:0] bits;
		bits = 6'($urandom);
		return {2'b10, bits};
	endfunction

	function automatic logic [u8dec_pkg::BYTE_W-1:0] lead_byte(input int len);
		logic [4:0] bits;
		bits = 5'($urandom);
		case (len)
			2:       return {3'b110, bits};
			3:       return {4'b1110, bits[3:0]};
			4:       return {5'b11110, bits[2:0]};
			5:       return {6'b111110, bits[1:0]};
			default: return {7'b1111110, bits[0]};
		endcase
	endfunction

	task automatic send_random_unit();
		int kind;
		int len;
		int k;
		logic [u8dec_pkg::BYTE_W-1:0] b;
		logic [3:0] nib;
		kind = $urandom_range(0, 99);
		nib  = 4'($urandom);
		if (kind < 25) begin
			send_byte(8'($urandom_range(1, 127)));
		end else if (kind < 55) begin
			len = $urandom_range(2, 6);
			send_byte(lead_byte(len));
			repeat (len - 1) send_byte(cont_byte());
		end else if (kind < 70) begin
			send_byte(8'hED);
			send_byte({4'b1010, nib});
			send_byte(cont_byte());
			k = $urandom_range(0, 9);
			if (k < 7) begin
				nib = 4'($urandom);
				send_byte(8'hED);
				send_byte({4'b1011, nib});
				send_byte(cont_byte());
			end else if (k < 9) begin
				send_byte(lead_byte(3));
				send_byte(cont_byte());
				send_byte(cont_byte());
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end else if (kind < 78) begin
			// drop the sequence early with a non-continuation byte
			len = $urandom_range(2, 6);
			send_byte(lead_byte(len));
			k = $urandom_range(0, len - 2);
			repeat (k) send_byte(cont_byte());
			b = 8'($urandom_range(0, 255));
			if (b[7:6] == 2'b10)
				b[6] = 1'b1;
			send_byte(b);
		end else if (kind < 88) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (kind < 93) begin
			send_byte(8'h00);
		end else begin
			send_byte(8'hED);
			send_byte({4'b1011, nib});
			send_byte(cont_byte());
		end
	endtask

	task automatic test_single_bytes();
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hFE);
		send_byte(8'hFF);
		send_byte(8'h00);
		wait_drained();
	endtask

	task automatic test_sequence_errors();
		send_byte(8'hC3);  // end mark mid-sequence
		send_byte(8'h00);
		send_byte(8'hC3);  // non-continuation consumed
		send_byte(8'h41);
		send_byte(8'hC0);  // overlong
		send_byte(8'h80);
		send_byte(8'hFD);  // largest six-byte value
		repeat (5) send_byte(8'hBF);
		wait_drained();
	endtask

	task automatic test_surrogates();
		send_byte(8'hED);  // lone low half
		send_byte(8'hB0);
		send_byte(8'h80);
		send_byte(8'hED);  // valid pair
		send_byte(8'hA0);
		send_byte(8'h80);
		send_byte(8'hED);
		send_byte(8'hB0);
		send_byte(8'h80);
		send_byte(8'hED);  // high half then ASCII
		send_byte(8'hA0);
		send_byte(8'h80);
		send_byte(8'h41);
		send_byte(8'hED);  // high half then a plain three-byte form
		send_byte(8'hAF);
		send_byte(8'hBF);
		send_byte(8'hE4);
		send_byte(8'hB8);
		send_byte(8'h80);
		wait_drained();
	endtask

	task automatic test_random_mix();
		int target;
		target = n_bytes + RANDOM_BYTES;
		while (n_bytes < target)
			send_random_unit();
		wait_drained();
	endtask

	task automatic test_output_hold();
		hold_requests++;
		repeat (40) send_byte(8'($urandom_range(1, 127)));
		wait_drained();
	endtask

	task automatic test_streaming();
		int target;
		idle_on = 1'b0;
		target  = n_bytes + STREAM_BYTES;
		while (n_bytes < target)
			send_random_unit();
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		test_sequence_errors();
		test_surrogates();
		test_random_mix();
		test_output_hold();
		test_streaming();
		repeat (10) @(posedge clk);
		$display("Decoded %0d bytes into %0d characters, %0d invalid flags, %0d end marks",
			n_bytes, n_chars, n_invalid, n_end);
		$display("with %0d surrogate pairs, random idling on both sides and a long output hold",
			n_pairs);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/u8dec_pkg.sv
sv/u8dec_core.sv
sv/u8dec_out.sv
sv/utf8_stream_decoder_top.sv
test/tb.sv
